// ===== rtl/sqe_pkg.sv =====
// Shared codes and widths for the stack and queue engine.
`timescale 1ns / 1ps
`default_nettype none
package sqe_pkg;

    localparam int ACT_W  = 3;
    localparam int STAT_W = 3;
    localparam int DATA_W = 32;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_action ACT_PUSH = 3'd0;
    localparam t_action ACT_DUMP = 3'd1;
    localparam t_action ACT_PEEK = 3'd2;
    localparam t_action ACT_POP  = 3'd3;
    localparam t_action ACT_SWAP = 3'd4;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_PEEK_EMPTY = 3'd1;
    localparam t_status ST_POP_EMPTY  = 3'd2;
    localparam t_status ST_SWAP_SHORT = 3'd3;
    localparam t_status ST_FULL       = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/stack_queue_engine.sv =====
// Top level of the stack and queue engine: circular value store with top pointer and count.
//
// Usage: an action word (push, dump, peek, pop, swap) is taken at a rising edge
// with i_start high and o_busy low. Results come out on o_out_value, o_status
// and o_last, each valid for exactly one cycle while o_strobe is high; the
// receiver cannot stall, so every result must be taken as it appears.
// The queue_mode register is written through i_cfg_valid / o_cfg_ready
// (i_cfg_data). Write it only while the block is idle; the block does not enforce it.
// Push, pop, peek and error results appear in the cycle after accept, dump words
// in the cycle after each read, the swap result after states S_SW1, S_SW2, S_SW3.
// Push, pop and peek leave the engine idle, so a new word may follow at once.
// Swap makes two reads and two writes through the single store port pair.
// Dump reads the held entries one at a time, limited by the one read port;
// its results stream top first, one per cycle.
// Reset (synchronous, active low) empties the engine and selects stack mode;
// store contents are left as they are and never read before written.
`timescale 1ns / 1ps
`default_nettype none
module stack_queue_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire sqe_pkg::t_action                 i_action,
    input  wire logic signed [sqe_pkg::DATA_W-1:0] i_push_value,
    output logic                                  o_strobe,
    output logic signed [sqe_pkg::DATA_W-1:0]     o_out_value,
    output sqe_pkg::t_status                      o_status,
    output logic                                  o_last,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic                             i_cfg_data
);
    import sqe_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DUMP = 3'd1;
    localparam logic [2:0] S_SW1  = 3'd2;
    localparam logic [2:0] S_SW2  = 3'd3;
    localparam logic [2:0] S_SW3  = 3'd4;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_top, n_top;
    logic [CW-1:0]     r_count, n_count;
    logic              r_queue, n_queue;
    logic [CW-1:0]     r_left, n_left;
    logic [AW-1:0]     r_addr, n_addr;
    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic              r_rd_out, n_rd_out;
    logic              r_rd_last, n_rd_last;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_res_valid, n_res_valid;
    t_status           r_res_status, n_res_status;

    logic              w_we, w_re, w_accept;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW:0]       w_bot_sum;
    logic [AW-1:0]     w_bot_addr, w_top_dec, w_top_inc;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        addr_inc = (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_top_inc  = addr_inc(r_top);
    assign w_top_dec  = (r_top == '0) ? LAST_ADDR : r_top - AW'(1);
    // slot below the bottom entry: top + count, wrapped once
    assign w_bot_sum  = (AW + 1)'(r_top) + (AW + 1)'(r_count);
    assign w_bot_addr = (w_bot_sum >= DEPTH_X) ? AW'(w_bot_sum - DEPTH_X)
                                               : w_bot_sum[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_count      = r_count;
        n_queue      = r_queue;
        n_left       = r_left;
        n_addr       = r_addr;
        n_tmp        = r_tmp;
        n_rd_out     = 1'b0;
        n_rd_last    = 1'b0;
        n_res_valid  = 1'b0;
        n_res_status = ST_OK;
        w_we         = 1'b0;
        w_waddr      = r_top;
        w_wdata      = i_push_value;
        w_re         = 1'b0;
        w_raddr      = r_top;

        if (i_cfg_valid) begin
            n_queue = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_PUSH: begin
                            n_res_valid = 1'b1;
                            if (r_count >= FULL_CNT) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                if (!r_queue || r_count == '0) begin
                                    if (r_count != '0) begin
                                        n_top   = w_top_dec;
                                        w_waddr = w_top_dec;
                                    end
                                end else begin
                                    w_waddr = w_bot_addr;
                                end
                            end
                        end
                        ACT_DUMP: begin
                            if (r_count != '0) begin
                                w_re      = 1'b1;
                                n_rd_out  = 1'b1;
                                n_rd_last = (r_count == CW'(1));
                                n_left    = r_count - CW'(1);
                                n_addr    = w_top_inc;
                                if (r_count != CW'(1)) begin
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        ACT_PEEK: begin
                            if (r_count == '0) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_PEEK_EMPTY;
                            end else begin
                                w_re      = 1'b1;
                                n_rd_out  = 1'b1;
                                n_rd_last = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            n_res_valid = 1'b1;
                            if (r_count == '0) begin
                                n_res_status = ST_POP_EMPTY;
                            end else begin
                                n_top   = w_top_inc;
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_SWAP: begin
                            if (r_count < CW'(2)) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_SWAP_SHORT;
                            end else begin
                                w_re    = 1'b1;
                                n_addr  = w_top_inc;
                                n_state = S_SW1;
                            end
                        end
                        default: begin
                            // undefined codes: drop the word
                        end
                    endcase
                end
            end
            S_DUMP: begin
                w_re      = 1'b1;
                w_raddr   = r_addr;
                n_rd_out  = 1'b1;
                n_rd_last = (r_left == CW'(1));
                n_left    = r_left - CW'(1);
                n_addr    = addr_inc(r_addr);
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SW1: begin
                // hold the top value, fetch the one below it
                n_tmp   = r_rd_data;
                w_re    = 1'b1;
                w_raddr = r_addr;
                n_state = S_SW2;
            end
            S_SW2: begin
                w_we    = 1'b1;
                w_waddr = r_top;
                w_wdata = r_rd_data;
                n_state = S_SW3;
            end
            S_SW3: begin
                w_we        = 1'b1;
                w_waddr     = r_addr;
                w_wdata     = r_tmp;
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_top        <= '0;
            r_count      <= '0;
            r_queue      <= 1'b0;
            r_left       <= '0;
            r_rd_out     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_res_valid  <= 1'b0;
            r_res_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_top        <= n_top;
            r_count      <= n_count;
            r_queue      <= n_queue;
            r_left       <= n_left;
            r_rd_out     <= n_rd_out;
            r_rd_last    <= n_rd_last;
            r_res_valid  <= n_res_valid;
            r_res_status <= n_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_tmp  <= n_tmp;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_rd_out || r_res_valid;
    assign o_out_value = r_rd_out ? r_rd_data : '0;
    assign o_status    = r_rd_out ? ST_OK : r_res_status;
    assign o_last      = r_rd_out ? r_rd_last : r_res_valid;

endmodule
`default_nettype wire

// ===== rtl/sqe_checker.sv =====
// Port-level checks for the stack and queue engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sqe_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_start,
    input wire logic                             o_busy,
    input wire sqe_pkg::t_action                 i_action,
    input wire logic signed [sqe_pkg::DATA_W-1:0] i_push_value,
    input wire logic                             o_strobe,
    input wire logic signed [sqe_pkg::DATA_W-1:0] o_out_value,
    input wire sqe_pkg::t_status                 o_status,
    input wire logic                             o_last,
    input wire logic                             i_cfg_valid,
    input wire logic                             o_cfg_ready,
    input wire logic                             i_cfg_data
);
    import sqe_pkg::*;

    // error words are single results with no value
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_OK |-> o_last && o_out_value == '0)
        else $error("error result not a single zero word");

    a_push_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_action == ACT_PUSH |=> o_strobe && o_last)
        else $error("push result missing");

    a_pop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_action == ACT_POP |=>
            o_strobe && (o_status == ST_OK || o_status == ST_POP_EMPTY))
        else $error("pop result missing or wrong code");

    a_peek_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_action == ACT_PEEK |=>
            o_strobe && o_last && (o_status == ST_OK || o_status == ST_PEEK_EMPTY))
        else $error("peek result missing or wrong code");

    a_busy_no_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy && o_strobe |-> o_status == ST_OK)
        else $error("error result while busy");

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the stack and queue engine, with a predicting scoreboard.
`timescale 1ns / 1ps
module testbench;
    import sqe_pkg::*;

    localparam int DEPTH         = 64;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // action codes the engine ignores
    localparam t_action ACT_UNDEF_LO = 3'd5;
    localparam t_action ACT_UNDEF_HI = 3'd7;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     last;
    } t_stack_result;

    class stack_scoreboard;
        logic signed [DATA_W-1:0] store [DEPTH];
        logic [PTR_W-1:0]         top_ptr;
        logic [PTR_W:0]           count;
        bit                       queue_mode;
        t_stack_result            expected_q [$];
        int                       mismatches;

        function new();
            top_ptr    = '0;
            count      = '0;
            queue_mode = 1'b0;
            mismatches = 0;
        endfunction

        function void set_mode(bit mode);
            queue_mode = mode;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_result(logic signed [DATA_W-1:0] value, t_status status, logic last);
            t_stack_result r;
            r.value  = value;
            r.status = status;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // Advance the predicted stack by one accepted word and queue its results.
        function void note_word(t_action act, logic signed [DATA_W-1:0] value);
            logic [PTR_W-1:0]         nxt;
            logic signed [DATA_W-1:0] held;
            nxt = top_ptr + 1'b1;
            case (act)
                ACT_PUSH: begin
                    if (count >= DEPTH) begin
                        add_result('0, ST_FULL, 1'b1);
                    end else begin
                        if (!queue_mode || count == 0) begin
                            if (count != 0)
                                top_ptr = top_ptr - 1'b1;
                            store[top_ptr] = value;
                        end else begin
                            store[top_ptr + count[PTR_W-1:0]] = value;
                        end
                        count = count + 1'b1;
                        add_result('0, ST_OK, 1'b1);
                    end
                end
                ACT_DUMP: begin
                    for (int i = 0; i < count; i++)
                        add_result(store[top_ptr + PTR_W'(i)], ST_OK, i == count - 1);
                end
                ACT_PEEK: begin
                    if (count == 0)
                        add_result('0, ST_PEEK_EMPTY, 1'b1);
                    else
                        add_result(store[top_ptr], ST_OK, 1'b1);
                end
                ACT_POP: begin
                    if (count == 0) begin
                        add_result('0, ST_POP_EMPTY, 1'b1);
                    end else begin
                        top_ptr = nxt;
                        count   = count - 1'b1;
                        add_result('0, ST_OK, 1'b1);
                    end
                end
                ACT_SWAP: begin
                    if (count < 2) begin
                        add_result('0, ST_SWAP_SHORT, 1'b1);
                    end else begin
                        held           = store[top_ptr];
                        store[top_ptr] = store[nxt];
                        store[nxt]     = held;
                        add_result('0, ST_OK, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [DATA_W-1:0] value, t_status status, logic last);
            t_stack_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d status %0d last %0d",
                             value, status, last);
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value || status !== want.status || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value %0d status %0d last %0d, got %0d %0d %0d",
                             want.value, want.status, want.last, value, status, last);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    t_action                  i_action;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_out_value;
    t_status                  o_status;
    logic                     o_last;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic                     i_cfg_data;

    stack_scoreboard sb = new();
    int unsigned     cycle_count = 0;
    int              burst_left  = 0;

    stack_queue_engine #(.DEPTH(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .o_strobe     (o_strobe),
        .o_out_value  (o_out_value),
        .o_status     (o_status),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_out_value, o_status, o_last);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Random idle gap before each word, with occasional back-to-back bursts.
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(8, 24);
        return $urandom_range(0, 7);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(t_action act, logic signed [DATA_W-1:0] value);
        int gap;
        gap = next_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action     = act;
        i_push_value = value;
        i_start      = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_word(act, value);
    endtask

    // Hold off until every queued result has come out and the engine settles.
    task automatic drain_results();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_mode(bit mode);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_mode(mode);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_phase(int n, int w_push, int w_pop, int w_peek, int w_swap, int w_dump);
        int      r;
        t_action act;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < w_push)
                act = ACT_PUSH;
            else if (r < w_push + w_pop)
                act = ACT_POP;
            else if (r < w_push + w_pop + w_peek)
                act = ACT_PEEK;
            else if (r < w_push + w_pop + w_peek + w_swap)
                act = ACT_SWAP;
            else if (r < w_push + w_pop + w_peek + w_swap + w_dump)
                act = ACT_DUMP;
            else
                act = t_action'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
            send_word(act, rand_value());
            if (k == n / 2)
                drain_results();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_action     = ACT_PUSH;
        i_push_value = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_mode(1'b0);
        // errors on an empty stack, empty dump, ignored codes
        send_word(ACT_PEEK, '0);
        send_word(ACT_POP, '0);
        send_word(ACT_SWAP, '0);
        send_word(ACT_DUMP, '0);
        send_word(ACT_UNDEF_LO, 32'sh1234_5678);
        send_word(ACT_UNDEF_HI, -1);
        send_word(ACT_PUSH, 32'sh7fff_ffff);
        send_word(ACT_SWAP, '0);
        send_word(ACT_PUSH, 32'sh8000_0000);
        send_word(ACT_PUSH, '0);
        send_word(ACT_PUSH, -1);
        send_word(ACT_PEEK, '0);
        send_word(ACT_SWAP, '0);
        send_word(ACT_DUMP, '0);
        repeat (4) send_word(ACT_POP, '0);
        send_word(ACT_POP, '0);

        // queue mode starting from an empty store
        write_mode(1'b1);
        send_word(ACT_PUSH, 32'sh0000_0005);
        send_word(ACT_PUSH, 32'sh8000_0000);
        send_word(ACT_PUSH, 32'sh7fff_ffff);
        send_word(ACT_DUMP, '0);
        send_word(ACT_SWAP, '0);
        send_word(ACT_PEEK, '0);
        send_word(ACT_DUMP, '0);

        write_mode(1'b0);
        run_phase(100, 75, 4, 7, 6, 4);
        write_mode(1'b1);
        run_phase(80, 45, 30, 8, 8, 5);
        write_mode(1'b1);
        run_phase(100, 75, 5, 6, 6, 4);
        write_mode(1'b0);
        run_phase(100, 10, 70, 7, 6, 4);

        drain_results();
        repeat (DEPTH + SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
